// File: sv/rcfg_pkg.sv
// Shared types and constants for the rainbow frame generator.
package rcfg_pkg;

   localparam int unsigned STRIP_LEN_W     = 7;
   localparam int unsigned LED_INDEX_W     = 6;
   localparam int unsigned COLOR_W         = 8;
   localparam int unsigned HUE_W           = 8;
   localparam int unsigned DIV_STEP_W      = 4;
   localparam logic [STRIP_LEN_W-1:0] STRIP_LEN_RESET = 7'd16;
   localparam logic [DIV_STEP_W-1:0]  DIV_TOP_STEP    = 4'd8;
   localparam logic [HUE_W-1:0]       HUE_SEG_1       = 8'd85;
   localparam logic [HUE_W-1:0]       HUE_SEG_2       = 8'd170;
   localparam logic [COLOR_W-1:0]     COLOR_MAX       = 8'd255;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

// File: sv/rainbow_cycle_frame_generator.sv
// Top level of the rainbow frame generator: sequencer, shared subtractor, colour wheel.
//
// Usage: each request on the req_ channel carries frame_tick. A request with
// frame_tick set produces one pixel write per LED on the rsp_ channel, strip
// position count-1-i for the i-th pixel, the last one flagged by frame_last;
// the hue offset then advances by one. A request with frame_tick clear emits
// nothing. A strip length of zero emits nothing but still advances the offset.
// Strip lengths above MAX_LEDS are clamped to MAX_LEDS.
// Timing: after a request is taken the block works out 256/count on one shared
// subtract-and-compare unit, one restoring step per cycle, then issues one pixel
// per cycle while rsp_ is not stalled, through the same unit, which steps the hue
// accumulator. req_stall stays high from the request until the last pixel is
// loaded into the output register.
// A stall on rsp_ holds the output register and pauses the pixel sequence.
// Reset (synchronous, active high) returns the strip length register to 16,
// the hue offset to zero and drops any pending output.
// csr_wr_en writes csr_wr_data into the strip length register; write only
// while the block is idle.
module rainbow_cycle_frame_generator
   import rcfg_pkg::*;
#(
   parameter int unsigned MAX_LEDS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_frame_tick,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [LED_INDEX_W-1:0] rsp_led_index,
   output logic [COLOR_W-1:0]     rsp_red,
   output logic [COLOR_W-1:0]     rsp_green,
   output logic [COLOR_W-1:0]     rsp_blue,
   output logic                   rsp_frame_last,
   input  logic                   csr_wr_en,
   input  logic [STRIP_LEN_W-1:0] csr_wr_data
);

   localparam int unsigned CNT_W = $clog2(MAX_LEDS + 1);

   state_type              state_ff, state_in;
   logic [STRIP_LEN_W-1:0] strip_len_ff, strip_len_in;
   logic [HUE_W-1:0]       hue_offset_ff, hue_offset_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       rem_ff, rem_in;
   logic [HUE_W-1:0]       quot_ff, quot_in;
   logic [DIV_STEP_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]       racc_ff, racc_in;
   logic [HUE_W-1:0]       qacc_ff, qacc_in;
   logic [CNT_W-1:0]       pix_ff, pix_in;
   logic                   out_valid_ff, out_valid_in;
   logic [LED_INDEX_W-1:0] out_index_ff, out_index_in;
   logic [COLOR_W-1:0]     out_red_ff, out_red_in;
   logic [COLOR_W-1:0]     out_green_ff, out_green_in;
   logic [COLOR_W-1:0]     out_blue_ff, out_blue_in;
   logic                   out_last_ff, out_last_in;

   logic [CNT_W:0]         sub_a;
   logic [CNT_W:0]         sub_diff;
   logic                   sub_ge;
   logic [CNT_W-1:0]       count_sat;
   logic                   req_take;
   logic                   out_free;
   logic                   pix_last;
   logic [HUE_W-1:0]       hue;
   logic [COLOR_W-1:0]     seg_h;
   logic [COLOR_W-1:0]     tri3;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign pix_last  = (pix_ff == count_ff - CNT_W'(1));

   assign count_sat = (strip_len_ff > STRIP_LEN_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS)
                                                               : CNT_W'(strip_len_ff);

   // shared subtract-and-compare unit
   always_comb begin
      if (state_ff == ST_DIV) begin
         sub_a = {rem_ff, (step_ff == DIV_TOP_STEP)};
      end else begin
         sub_a = {1'b0, racc_ff} + {1'b0, rem_ff};
      end
      sub_ge   = (sub_a >= {1'b0, count_ff});
      sub_diff = sub_a - {1'b0, count_ff};
   end

   // colour wheel
   always_comb begin
      hue = qacc_ff + hue_offset_ff;
      priority if (hue < HUE_SEG_1) begin
         seg_h = hue;
      end else if (hue < HUE_SEG_2) begin
         seg_h = hue - HUE_SEG_1;
      end else begin
         seg_h = hue - HUE_SEG_2;
      end
      tri3 = {seg_h[COLOR_W-2:0], 1'b0} + seg_h;
      priority if (hue < HUE_SEG_1) begin
         out_red_in   = tri3;
         out_green_in = COLOR_MAX - tri3;
         out_blue_in  = '0;
      end else if (hue < HUE_SEG_2) begin
         out_red_in   = COLOR_MAX - tri3;
         out_green_in = '0;
         out_blue_in  = tri3;
      end else begin
         out_red_in   = '0;
         out_green_in = tri3;
         out_blue_in  = COLOR_MAX - tri3;
      end
      out_index_in = LED_INDEX_W'(count_ff - CNT_W'(1) - pix_ff);
      out_last_in  = pix_last;
   end

   always_comb begin
      state_in      = state_ff;
      strip_len_in  = csr_wr_en ? csr_wr_data : strip_len_ff;
      hue_offset_in = hue_offset_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      step_in       = step_ff;
      racc_in       = racc_ff;
      qacc_in       = qacc_ff;
      pix_in        = pix_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_frame_tick) begin
               count_in = count_sat;
               rem_in   = '0;
               quot_in  = '0;
               step_in  = DIV_TOP_STEP;
               if (count_sat == '0) begin
                  hue_offset_in = hue_offset_ff + HUE_W'(1);
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rem_in  = sub_ge ? sub_diff[CNT_W-1:0] : sub_a[CNT_W-1:0];
            quot_in = {quot_ff[HUE_W-2:0], sub_ge};
            step_in = step_ff - DIV_STEP_W'(1);
            if (step_ff == '0) begin
               racc_in  = '0;
               qacc_in  = '0;
               pix_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               racc_in      = sub_ge ? sub_diff[CNT_W-1:0] : sub_a[CNT_W-1:0];
               qacc_in      = qacc_ff + quot_ff + HUE_W'(sub_ge);
               pix_in       = pix_ff + CNT_W'(1);
               if (pix_last) begin
                  hue_offset_in = hue_offset_ff + HUE_W'(1);
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         strip_len_ff  <= STRIP_LEN_RESET;
         hue_offset_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         strip_len_ff  <= strip_len_in;
         hue_offset_ff <= hue_offset_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      step_ff  <= step_in;
      racc_ff  <= racc_in;
      qacc_ff  <= qacc_in;
      pix_ff   <= pix_in;
      if ((state_ff == ST_EMIT) && out_free) begin
         out_index_ff <= out_index_in;
         out_red_ff   <= out_red_in;
         out_green_ff <= out_green_in;
         out_blue_ff  <= out_blue_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_led_index  = out_index_ff;
   assign rsp_red        = out_red_ff;
   assign rsp_green      = out_green_ff;
   assign rsp_blue       = out_blue_ff;
   assign rsp_frame_last = out_last_ff;

endmodule

// File: sv/rcfg_checker.sv
// Port-level checks for the rainbow frame generator, bound to the top level.
module rcfg_checker
   import rcfg_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [LED_INDEX_W-1:0] rsp_led_index,
   input logic [COLOR_W-1:0]     rsp_red,
   input logic [COLOR_W-1:0]     rsp_green,
   input logic [COLOR_W-1:0]     rsp_blue,
   input logic                   rsp_frame_last
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_led_index) && $stable(rsp_red)
         && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_frame_last))
      else $error("stalled response changed");

   a_reset_drop: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_busy_mid_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_last |-> req_stall)
      else $error("request taken in the middle of a frame");

   a_last_at_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_last |-> (rsp_led_index == '0))
      else $error("frame ends away from strip position zero");

   a_wheel_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((9'(rsp_red) + 9'(rsp_green) + 9'(rsp_blue)) == 9'(COLOR_MAX)))
      else $error("colour wheel components do not sum to full scale");

endmodule

bind rainbow_cycle_frame_generator rcfg_checker u_rcfg_checker (.*);
